[design/cdas_pkg.sv]
// Shared types, constants and tables for the calendar date add/subtract block.
// Holds the microprogram, the month tables and the control word layout.
// Depends on nothing; every other design file refers to it by scoped names.
package cdas_pkg;

  localparam int YEAR_BITS      = 16;
  localparam int DAY_COUNT_BITS = 16;
  localparam int DAY_BITS       = 5;
  localparam int MONTH_BITS     = 4;
  localparam int DOY_BITS       = 9;
  localparam int DIST_BITS      = 25;

  // Day numbers count from Jan 1 of the smallest year; they fit in U_BITS.
  localparam int U_BITS    = 25;
  localparam int ACC_BITS  = U_BITS + 2;
  localparam int PROD_BITS = 2 * U_BITS;

  localparam int DAYS_PER_YEAR = 365;

  // floor(2**RECIP_SHIFT / 365); the quotient it yields is exact or one short.
  localparam int                RECIP_SHIFT = 33;
  localparam logic [U_BITS-1:0] RECIP       = 25'd23534067;

  // Day number of Dec 31 of the largest year.
  localparam logic [U_BITS-1:0]    LAST_DAY_NUM = 25'd23920274;
  localparam logic [DIST_BITS-1:0] DIST_MAX     = '1;
  localparam logic [MONTH_BITS-1:0] LAST_MONTH  = 4'd11;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_DIST = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Program steps. Load and distance each enter at their own first step; add and subtract share one.
  typedef enum logic [4:0] {
    P_LOAD,
    P_MV_YEAR,
    P_MV_MUL,
    P_MV_ABS,
    P_MV_STEP,
    P_MV_CLAMP,
    P_MV_RECIP,
    P_MV_QUO,
    P_MV_BACK,
    P_MV_REM,
    P_MV_CORR,
    P_MV_LAST,
    P_MV_SEARCH,
    P_MV_WB,
    P_DI_YEAR_A,
    P_DI_MUL_A,
    P_DI_ABS_A,
    P_DI_YEAR_B,
    P_DI_MUL_B,
    P_DI_ABS_B,
    P_DI_WB
  } step_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ABS,
    ACC_STEP,
    ACC_CLAMP,
    ACC_REM,
    ACC_CORR
  } acc_sel_t;

  typedef enum logic [1:0] {
    QUO_HOLD,
    QUO_YEAR,
    QUO_PROD,
    QUO_CORR
  } quo_sel_t;

  typedef enum logic [1:0] {
    MON_HOLD,
    MON_SRC,
    MON_LAST,
    MON_SEARCH
  } mon_sel_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_YEAR,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_LOAD,
    WB_MOVE,
    WB_DIST
  } wb_sel_t;

  typedef enum logic [0:0] {
    COND_NEVER,
    COND_MS_GT
  } cond_t;

  typedef struct packed {
    acc_sel_t acc_sel;
    quo_sel_t quo_sel;
    mon_sel_t mon_sel;
    mul_sel_t mul_sel;
    logic     src_given;
    logic     save_tmp;
    wb_sel_t  wb_sel;
    cond_t    cond;
    step_t    target;
    logic     last;
  } uword_t;

  typedef struct packed {
    logic [DAY_BITS-1:0]         day;
    logic [MONTH_BITS-1:0]       month;
    logic signed [YEAR_BITS-1:0] year;
    logic                        month_changed;
    logic                        year_changed;
    logic [DIST_BITS-1:0]        distance;
  } result_t;

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_BITS-1:0] month_start(input logic [MONTH_BITS-1:0] m);
    logic [DOY_BITS-1:0] start;
    case (m)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd59;
      4'd3:    start = 9'd90;
      4'd4:    start = 9'd120;
      4'd5:    start = 9'd151;
      4'd6:    start = 9'd181;
      4'd7:    start = 9'd212;
      4'd8:    start = 9'd243;
      4'd9:    start = 9'd273;
      4'd10:   start = 9'd304;
      default: start = 9'd334;
    endcase
    return start;
  endfunction

  function automatic step_t entry_step(input op_t op);
    step_t s;
    case (op)
      OP_LOAD: s = P_LOAD;
      OP_ADD,
      OP_SUB:  s = P_MV_YEAR;
      default: s = P_DI_YEAR_A;
    endcase
    return s;
  endfunction

  // The microprogram. Fields left at zero mean hold, no multiply, no write.
  function automatic uword_t urom(input step_t pc);
    uword_t w;
    w = '0;
    case (pc)
      P_LOAD: begin
        w.wb_sel = WB_LOAD;
        w.last   = 1'b1;
      end
      P_MV_YEAR, P_DI_YEAR_A: begin
        w.quo_sel = QUO_YEAR;
        w.mon_sel = MON_SRC;
      end
      P_MV_MUL, P_DI_MUL_A, P_DI_MUL_B, P_MV_BACK: begin
        w.mul_sel = MUL_YEAR;
      end
      P_MV_ABS, P_DI_ABS_A: begin
        w.acc_sel = ACC_ABS;
      end
      P_MV_STEP: begin
        w.acc_sel = ACC_STEP;
      end
      P_MV_CLAMP: begin
        w.acc_sel = ACC_CLAMP;
      end
      P_MV_RECIP: begin
        w.mul_sel = MUL_RECIP;
      end
      P_MV_QUO: begin
        w.quo_sel = QUO_PROD;
      end
      P_MV_REM: begin
        w.acc_sel = ACC_REM;
      end
      P_MV_CORR: begin
        w.acc_sel = ACC_CORR;
        w.quo_sel = QUO_CORR;
      end
      P_MV_LAST: begin
        w.mon_sel = MON_LAST;
      end
      P_MV_SEARCH: begin
        w.mon_sel = MON_SEARCH;
        w.cond    = COND_MS_GT;
        w.target  = P_MV_SEARCH;
      end
      P_MV_WB: begin
        w.wb_sel = WB_MOVE;
        w.last   = 1'b1;
      end
      P_DI_YEAR_B: begin
        w.quo_sel   = QUO_YEAR;
        w.mon_sel   = MON_SRC;
        w.src_given = 1'b1;
        w.save_tmp  = 1'b1;
      end
      P_DI_ABS_B: begin
        w.acc_sel   = ACC_ABS;
        w.src_given = 1'b1;
      end
      P_DI_WB: begin
        w.wb_sel = WB_DIST;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[design/cdas_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on cdas_pkg for the program, the step codes and the control word.
module cdas_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cdas_pkg::op_t    opcode,
  input  logic             hold,
  input  logic             ms_gt,
  output cdas_pkg::uword_t uw,
  output logic             exec,
  output logic             busy
);

  cdas_pkg::seq_state_t state, state_next;
  cdas_pkg::step_t      pc, pc_next;
  logic                 taken;

  assign uw    = cdas_pkg::urom(pc);
  assign busy  = (state == cdas_pkg::SEQ_RUN);
  assign taken = (uw.cond == cdas_pkg::COND_MS_GT) && ms_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdas_pkg::SEQ_IDLE;
      pc    <= cdas_pkg::P_LOAD;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    exec       = 1'b0;
    case (state)
      cdas_pkg::SEQ_IDLE: begin
        if (start) begin
          pc_next    = cdas_pkg::entry_step(opcode);
          state_next = cdas_pkg::SEQ_RUN;
        end
      end
      cdas_pkg::SEQ_RUN: begin
        // The closing step waits while the previous result is still unread.
        exec = !(uw.last && hold);
        if (exec) begin
          if (taken) begin
            pc_next = uw.target;
          end else if (uw.last) begin
            state_next = cdas_pkg::SEQ_IDLE;
          end else begin
            pc_next = cdas_pkg::step_t'(pc + 5'd1);
          end
        end
      end
      default: begin
        state_next = cdas_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

[design/cdas_dp.sv]
// Datapath: date state, operand latches, working registers and the shared multiplier.
// Depends on cdas_pkg; driven one control word per cycle by cdas_seq while exec is high.
module cdas_dp (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load_in,
  input  cdas_pkg::op_t                               opcode,
  input  logic [cdas_pkg::DAY_COUNT_BITS-1:0]         day_count,
  input  logic [cdas_pkg::DAY_BITS-1:0]               given_day,
  input  logic [cdas_pkg::MONTH_BITS-1:0]             given_month,
  input  logic signed [cdas_pkg::YEAR_BITS-1:0]       given_year,
  input  logic                                        exec,
  input  cdas_pkg::uword_t                            uw,
  output logic                                        ms_gt,
  output cdas_pkg::result_t                           res
);

  localparam int Y  = cdas_pkg::YEAR_BITS;
  localparam int AB = cdas_pkg::ACC_BITS;

  // Operands of the item in progress, normalized on capture.
  cdas_pkg::op_t                        opr;
  logic [cdas_pkg::DAY_COUNT_BITS-1:0]  cnt;
  logic [cdas_pkg::DAY_BITS-1:0]        gd;
  logic [cdas_pkg::MONTH_BITS-1:0]      gm;
  logic signed [Y-1:0]                  gy;

  // Stored date.
  logic [cdas_pkg::DAY_BITS-1:0]        day_reg;
  logic [cdas_pkg::MONTH_BITS-1:0]      month_reg;
  logic signed [Y-1:0]                  year_reg;

  // Working registers.
  logic signed [AB-1:0]                 acc, acc_next;
  logic signed [AB-1:0]                 tmp;
  logic [Y-1:0]                         quo, quo_next;
  logic [cdas_pkg::MONTH_BITS-1:0]      mon, mon_next;
  logic [cdas_pkg::PROD_BITS-1:0]       prod;

  logic                                 mch, ych;
  logic [cdas_pkg::DIST_BITS-1:0]       distance;

  logic [cdas_pkg::MONTH_BITS-1:0]      gm_n;
  logic [cdas_pkg::DAY_BITS-1:0]        ml_n, gd_n;
  logic signed [Y-1:0]                  gy_n;

  logic signed [Y-1:0]                  src_year;
  logic [cdas_pkg::MONTH_BITS-1:0]      src_month;
  logic [cdas_pkg::DAY_BITS-1:0]        src_day;
  logic [Y-1:0]                         src_idx;
  logic                                 src_pos;

  logic [cdas_pkg::DOY_BITS-1:0]        ms_cur;
  logic signed [AB-1:0]                 ms_ext, cnt_ext, prod_ext, day_ext;
  logic                                 rem_big;
  logic [cdas_pkg::U_BITS-1:0]          mul_a, mul_b;

  logic [cdas_pkg::DOY_BITS-1:0]        dom;
  logic [cdas_pkg::DAY_BITS-1:0]        new_day;
  logic signed [Y-1:0]                  new_year;
  logic signed [AB-1:0]                 diff, diff_abs;
  logic [cdas_pkg::DIST_BITS-1:0]       dist_sat;

  // Input normalization: month clipped to december, day clipped into the month,
  // year zero taken as year one.
  always_comb begin
    gm_n = (given_month > cdas_pkg::LAST_MONTH) ? cdas_pkg::LAST_MONTH : given_month;
    ml_n = cdas_pkg::month_len(gm_n);
    if (given_day == '0) begin
      gd_n = 5'd1;
    end else if (given_day > ml_n) begin
      gd_n = ml_n;
    end else begin
      gd_n = given_day;
    end
    gy_n = (given_year == '0) ? Y'(1) : given_year;
  end

  // Year index counts years from the smallest one with no gap at year zero.
  always_comb begin
    src_year  = uw.src_given ? gy : year_reg;
    src_month = uw.src_given ? gm : month_reg;
    src_day   = uw.src_given ? gd : day_reg;
    src_pos   = !src_year[Y-1] && (src_year != '0);
    src_idx   = {~src_year[Y-1], src_year[Y-2:0]} - {{(Y-1){1'b0}}, src_pos};
  end

  always_comb begin
    ms_cur   = cdas_pkg::month_start(mon);
    ms_ext   = $signed({{(AB-cdas_pkg::DOY_BITS){1'b0}}, ms_cur});
    cnt_ext  = $signed({{(AB-cdas_pkg::DAY_COUNT_BITS){1'b0}}, cnt});
    prod_ext = $signed({{(AB-cdas_pkg::U_BITS){1'b0}}, prod[cdas_pkg::U_BITS-1:0]});
    day_ext  = $signed({{(AB-cdas_pkg::DAY_BITS){1'b0}}, src_day});
    ms_gt    = ms_ext > acc;
    rem_big  = acc >= $signed(AB'(cdas_pkg::DAYS_PER_YEAR));
  end

  always_comb begin
    if (uw.mul_sel == cdas_pkg::MUL_YEAR) begin
      mul_a = {{(cdas_pkg::U_BITS-Y){1'b0}}, quo};
      mul_b = cdas_pkg::U_BITS'(cdas_pkg::DAYS_PER_YEAR);
    end else begin
      mul_a = acc[cdas_pkg::U_BITS-1:0];
      mul_b = cdas_pkg::RECIP;
    end
  end

  always_comb begin
    acc_next = acc;
    case (uw.acc_sel)
      cdas_pkg::ACC_ABS:  acc_next = prod_ext + ms_ext + day_ext - AB'(1);
      cdas_pkg::ACC_STEP: acc_next = (opr == cdas_pkg::OP_SUB) ? acc - cnt_ext : acc + cnt_ext;
      cdas_pkg::ACC_CLAMP: begin
        if (acc < 0) begin
          acc_next = '0;
        end else if (acc > $signed({2'b00, cdas_pkg::LAST_DAY_NUM})) begin
          acc_next = $signed({2'b00, cdas_pkg::LAST_DAY_NUM});
        end
      end
      cdas_pkg::ACC_REM:  acc_next = acc - prod_ext;
      cdas_pkg::ACC_CORR: begin
        if (rem_big) begin
          acc_next = acc - $signed(AB'(cdas_pkg::DAYS_PER_YEAR));
        end
      end
      default: acc_next = acc;
    endcase
  end

  always_comb begin
    quo_next = quo;
    case (uw.quo_sel)
      cdas_pkg::QUO_YEAR: quo_next = src_idx;
      cdas_pkg::QUO_PROD: quo_next = prod[cdas_pkg::RECIP_SHIFT +: Y];
      cdas_pkg::QUO_CORR: quo_next = rem_big ? quo + Y'(1) : quo;
      default:            quo_next = quo;
    endcase
  end

  always_comb begin
    mon_next = mon;
    case (uw.mon_sel)
      cdas_pkg::MON_SRC:    mon_next = src_month;
      cdas_pkg::MON_LAST:   mon_next = cdas_pkg::LAST_MONTH;
      cdas_pkg::MON_SEARCH: mon_next = ms_gt ? mon - 4'd1 : mon;
      default:              mon_next = mon;
    endcase
  end

  // Back from day of year and year index to the calendar date.
  always_comb begin
    dom      = acc[cdas_pkg::DOY_BITS-1:0] - ms_cur + 9'd1;
    new_day  = dom[cdas_pkg::DAY_BITS-1:0];
    new_year = $signed({~quo[Y-1], quo[Y-2:0]} + {{(Y-1){1'b0}}, quo[Y-1]});
    diff     = tmp - acc;
    diff_abs = (diff < 0) ? -diff : diff;
    if (diff_abs > $signed({{(AB-cdas_pkg::DIST_BITS){1'b0}}, cdas_pkg::DIST_MAX})) begin
      dist_sat = cdas_pkg::DIST_MAX;
    end else begin
      dist_sat = diff_abs[cdas_pkg::DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      opr <= opcode;
      cnt <= day_count;
      gd  <= gd_n;
      gm  <= gm_n;
      gy  <= gy_n;
    end
    if (exec) begin
      acc <= acc_next;
      quo <= quo_next;
      mon <= mon_next;
      if (uw.mul_sel != cdas_pkg::MUL_NONE) begin
        prod <= mul_a * mul_b;
      end
      if (uw.save_tmp) begin
        tmp <= acc;
      end
      case (uw.wb_sel)
        cdas_pkg::WB_LOAD: begin
          mch      <= 1'b0;
          ych      <= 1'b0;
          distance <= '0;
        end
        cdas_pkg::WB_MOVE: begin
          ych      <= (new_year != year_reg);
          mch      <= (new_year != year_reg) || (mon != month_reg);
          distance <= '0;
        end
        cdas_pkg::WB_DIST: begin
          mch      <= 1'b0;
          ych      <= 1'b0;
          distance <= dist_sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= 5'd1;
      month_reg <= '0;
      year_reg  <= Y'(1);
    end else if (exec) begin
      case (uw.wb_sel)
        cdas_pkg::WB_LOAD: begin
          day_reg   <= gd;
          month_reg <= gm;
          year_reg  <= gy;
        end
        cdas_pkg::WB_MOVE: begin
          day_reg   <= new_day;
          month_reg <= mon;
          year_reg  <= new_year;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.day           = day_reg;
  assign res.month         = month_reg;
  assign res.year          = year_reg;
  assign res.month_changed = mch;
  assign res.year_changed  = ych;
  assign res.distance      = distance;

  // The stored date is always a real date.
  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (day_reg >= 5'd1) && (day_reg <= cdas_pkg::month_len(month_reg)) &&
    (month_reg <= cdas_pkg::LAST_MONTH) && (year_reg != '0))
    else $error("stored date out of range");

  // Saturation leaves a day number inside the calendar.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (exec && (uw.acc_sel == cdas_pkg::ACC_CLAMP)) |=>
    ((acc >= 0) && (acc <= $signed({2'b00, cdas_pkg::LAST_DAY_NUM}))))
    else $error("clamped day number out of range");

  // At write back the remainder is a day of year and the month search has settled.
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    (exec && (uw.wb_sel == cdas_pkg::WB_MOVE)) |->
    ((acc >= 0) && !rem_big && !ms_gt && (mon <= cdas_pkg::LAST_MONTH)))
    else $error("month search not settled at write back");

endmodule

[design/calendar_date_add_subtract.sv]
// Calendar date add/subtract on a 365-day calendar without leap years or year zero.
// Load, distance and add or subtract each run their own program steps; in add or subtract
// the month search runs one month per cycle, up to 11 extra steps.
// One item at a time: the next word is taken the cycle after the result is registered.
// Synchronous active-high reset: stored date Jan 1 of year 1, sequencer idle, no result.
// Depends on cdas_pkg, cdas_seq and cdas_dp.
module calendar_date_add_subtract (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: day_count[15:0], given_day[20:16], given_month[24:21],
  // given_year[40:25], zero padding[47:41].
  input  logic [47:0] s_tdata,
  // s_tuser, from bit 0: opcode[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: cur_day[4:0], cur_month[8:5], cur_year[24:9],
  // month_changed[25], year_changed[26], distance[51:27], zero padding[55:52].
  output logic [55:0] m_tdata
);

  // The sequencer walks a short program in its control store; each step's control
  // word tells the datapath which register to load and from where. Add and subtract
  // turn the date into a day number, move it, saturate it, split it back into year
  // and day of year with a reciprocal multiply, then search the month table from
  // December downward. Distance turns both dates into day numbers and subtracts.

  logic              accept;
  logic              busy;
  logic              exec;
  logic              hold;
  logic              ms_gt;
  cdas_pkg::uword_t  uw;
  cdas_pkg::result_t res;
  cdas_pkg::op_t     opcode;

  assign opcode   = cdas_pkg::op_t'(s_tuser);
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // A result waiting for the sink keeps the closing step of the next item from
  // running, so the state and the result register are never overwritten early.
  assign hold = m_tvalid && !m_tready;

  cdas_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .opcode (opcode),
    .hold   (hold),
    .ms_gt  (ms_gt),
    .uw     (uw),
    .exec   (exec),
    .busy   (busy)
  );

  cdas_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .load_in     (accept),
    .opcode      (opcode),
    .day_count   (s_tdata[15:0]),
    .given_day   (s_tdata[20:16]),
    .given_month (s_tdata[24:21]),
    .given_year  ($signed(s_tdata[40:25])),
    .exec        (exec),
    .uw          (uw),
    .ms_gt       (ms_gt),
    .res         (res)
  );

  // The result register is the datapath's result fields plus this valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec && uw.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0000, res.distance, res.year_changed, res.month_changed,
                    res.year, res.month, res.day};

endmodule

[dv/calendar_date_add_subtract_checker.sv]
// Scoreboard for the calendar date block: watches both stream channels, keeps its own
// copy of the stored date, predicts every result word and compares it field by field.
// Depends on cdas_pkg for the opcode enum, the result struct and the year and distance widths.
`timescale 1ns / 1ps

module calendar_date_add_subtract_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          results_due
);

  localparam longint YEAR_TOP     = (longint'(1) << (cdas_pkg::YEAR_BITS - 1)) - 1;
  localparam longint YEAR_BOTTOM  = -(longint'(1) << (cdas_pkg::YEAR_BITS - 1));
  localparam longint DAYS_IN_YEAR = 365;
  localparam longint FIRST_DAYNUM = YEAR_BOTTOM * DAYS_IN_YEAR;
  localparam longint LAST_DAYNUM  = (YEAR_TOP - 1) * DAYS_IN_YEAR + DAYS_IN_YEAR - 1;
  localparam longint DISTANCE_CAP = (longint'(1) << cdas_pkg::DIST_BITS) - 1;

  logic [4:0]         cal_day;
  logic [3:0]         cal_month;
  logic signed [15:0] cal_year;
  cdas_pkg::result_t  dates_expected[$];

  function automatic int days_in_month(input int m);
    case (m)
      1:           return 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int days_before_month(input int m);
    int total;
    total = 0;
    for (int k = 0; k < m; k++) total += days_in_month(k);
    return total;
  endfunction

  // Years skip zero, so year 1 and year -1 sit next to each other.
  function automatic longint day_number(input int d, input int m, input longint y);
    longint year_index;
    year_index = (y > 0) ? y - 1 : y;
    return year_index * DAYS_IN_YEAR + days_before_month(m) + d - 1;
  endfunction

  // Applies one accepted word to the stored date and returns the word it should produce.
  function automatic cdas_pkg::result_t apply_date_word(input logic [1:0] op,
                                                        input logic [47:0] word);
    int                gd, gm, nd, nm;
    longint            gy, now_num, target_num, step_days, span, doy, ny;
    cdas_pkg::result_t r;
    gd = int'(word[20:16]);
    gm = int'(word[24:21]);
    gy = longint'($signed(word[40:25]));
    step_days = longint'(word[15:0]);
    if (gm > 11) gm = 11;
    if (gd == 0) gd = 1;
    if (gd > days_in_month(gm)) gd = days_in_month(gm);
    if (gy == 0) gy = 1;
    r = '0;
    now_num = day_number(int'(cal_day), int'(cal_month), longint'(cal_year));
    case (cdas_pkg::op_t'(op))
      cdas_pkg::OP_LOAD: begin
        cal_day   = 5'(gd);
        cal_month = 4'(gm);
        cal_year  = 16'(gy);
      end
      cdas_pkg::OP_DIST: begin
        target_num = day_number(gd, gm, gy);
        span = (now_num > target_num) ? now_num - target_num : target_num - now_num;
        if (span > DISTANCE_CAP) span = DISTANCE_CAP;
        r.distance = 25'(span);
      end
      default: begin
        if (cdas_pkg::op_t'(op) == cdas_pkg::OP_ADD) begin
          target_num = now_num + step_days;
          if (target_num > LAST_DAYNUM) target_num = LAST_DAYNUM;
        end else begin
          target_num = now_num - step_days;
          if (target_num < FIRST_DAYNUM) target_num = FIRST_DAYNUM;
        end
        doy = (target_num - FIRST_DAYNUM) % DAYS_IN_YEAR;
        ny  = (target_num - FIRST_DAYNUM) / DAYS_IN_YEAR + YEAR_BOTTOM;
        if (ny >= 0) ny++;
        nm = 11;
        while (nm > 0 && days_before_month(nm) > doy) nm--;
        nd = int'(doy - longint'(days_before_month(nm)) + 1);
        r.year_changed  = (ny != longint'(cal_year));
        r.month_changed = r.year_changed || (nm != int'(cal_month));
        cal_day   = 5'(nd);
        cal_month = 4'(nm);
        cal_year  = 16'(ny);
      end
    endcase
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    $display("%0t: date result mismatch in %s: got %0d, expected %0d",
             $time, what, got_v, want_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cdas_pkg::result_t got, want;
    if (rst) begin
      cal_day   = 5'd1;
      cal_month = 4'd0;
      cal_year  = 16'sd1;
      dates_expected.delete();
      results_due <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.day           = m_tdata[4:0];
        got.month         = m_tdata[8:5];
        got.year          = m_tdata[24:9];
        got.month_changed = m_tdata[25];
        got.year_changed  = m_tdata[26];
        got.distance      = m_tdata[51:27];
        if (dates_expected.size() == 0) begin
          report_mismatch("word with no expectation, day", longint'(got.day), longint'(0));
        end else begin
          want = dates_expected.pop_front();
          if (got.day !== want.day)
            report_mismatch("cur_day", longint'(got.day), longint'(want.day));
          if (got.month !== want.month)
            report_mismatch("cur_month", longint'(got.month), longint'(want.month));
          if (got.year !== want.year)
            report_mismatch("cur_year", longint'(got.year), longint'(want.year));
          if (got.month_changed !== want.month_changed)
            report_mismatch("month_changed", longint'(got.month_changed),
                            longint'(want.month_changed));
          if (got.year_changed !== want.year_changed)
            report_mismatch("year_changed", longint'(got.year_changed),
                            longint'(want.year_changed));
          if (got.distance !== want.distance)
            report_mismatch("distance", longint'(got.distance), longint'(want.distance));
        end
      end
      if (s_tvalid && s_tready) dates_expected.push_back(apply_date_word(s_tuser, s_tdata));
      results_due <= dates_expected.size();
    end
  end

endmodule

[dv/calendar_date_add_subtract_test.sv]
// Top of the calendar date testbench: clock, reset, input words and output back-pressure.
// Depends on cdas_pkg, the calendar_date_add_subtract block and the date checker module.
`timescale 1ns / 1ps

module calendar_date_add_subtract_test;

  // Four phases of random words follow the directed ones; the checker does all comparing.
  localparam int WORDS_PER_PHASE = 440;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // The slowest operation is an add or subtract.
  localparam int DRAIN_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  int fail_count;
  int results_due;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  always #5 clk = ~clk;

  calendar_date_add_subtract dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  calendar_date_add_subtract_checker date_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // The receiver stalls each cycle with the probability set by the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one word, possibly after some idle cycles, and returns at the falling edge
  // after it was accepted. The valid line is only ever assigned once per time step.
  task automatic send_word(input cdas_pkg::op_t op, input logic [15:0] count,
                           input logic [4:0] day, input logic [3:0] month,
                           input logic [15:0] year);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, year, month, day, count};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Years cluster at both range ends, so that long moves saturate, and around the
  // missing year zero; the rest spread over the whole signed range.
  function automatic logic [15:0] pick_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'(32767 - $urandom_range(0, 300));
    if (r < 30) return 16'(-32768 + $urandom_range(0, 300));
    if (r < 45) return 16'($urandom_range(0, 6) - 3);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 50) return 16'($urandom_range(1, 40));
    if (r < 80) return 16'($urandom_range(0, 800));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly well-formed loads followed by moves, with distance queries and some words
  // whose date fields are plain random bits.
  task automatic send_random_word();
    int            kind;
    logic [15:0]   year;
    cdas_pkg::op_t move_op;
    kind    = $urandom_range(0, 99);
    year    = pick_year();
    move_op = $urandom_range(0, 1) ? cdas_pkg::OP_ADD : cdas_pkg::OP_SUB;
    if (kind < 45)
      send_word(move_op, pick_count(), 5'($urandom), 4'($urandom), 16'($urandom));
    else if (kind < 60)
      send_word(cdas_pkg::OP_LOAD, 16'($urandom), 5'($urandom_range(1, 31)),
                4'($urandom_range(0, 11)), year);
    else if (kind < 66)
      send_word(cdas_pkg::OP_LOAD, 16'($urandom), 5'($urandom), 4'($urandom), 16'($urandom));
    else if (kind < 82)
      send_word(cdas_pkg::OP_DIST, 16'($urandom), 5'($urandom_range(1, 31)),
                4'($urandom_range(0, 11)), year);
    else if (kind < 88)
      send_word(cdas_pkg::OP_DIST, 16'($urandom), 5'($urandom), 4'($urandom), 16'($urandom));
    else
      send_word(move_op, 16'($urandom_range(0, 65535)), 5'($urandom), 4'($urandom),
                16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words. The stored date starts at Jan 1 of year 1, so the first
    // distance to that same date must be zero.
    send_word(cdas_pkg::OP_DIST, 16'd0, 5'd1, 4'd0, 16'd1);
    // Moves by zero days leave the date alone and raise no flag.
    send_word(cdas_pkg::OP_ADD, 16'd0, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_SUB, 16'd0, 5'd0, 4'd0, 16'd0);
    // Walk to the end of January, over into February and back again.
    send_word(cdas_pkg::OP_ADD, 16'd30, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_ADD, 16'd1, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_SUB, 16'd1, 5'd0, 4'd0, 16'd0);
    // Back across the new year: Dec 31 of year -1 comes right before year 1.
    send_word(cdas_pkg::OP_SUB, 16'd31, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_ADD, 16'd1, 5'd0, 4'd0, 16'd0);
    // A load with a zero day, a month past December and year zero, all clamped.
    send_word(cdas_pkg::OP_LOAD, 16'hFFFF, 5'd0, 4'd15, 16'd0);
    // A day past the end of February is pulled back to the 28th.
    send_word(cdas_pkg::OP_LOAD, 16'd0, 5'd31, 4'd1, 16'd5);
    send_word(cdas_pkg::OP_ADD, 16'd365, 5'd0, 4'd0, 16'd0);
    // At the very last day an add saturates with no crossing; then a full subtract.
    send_word(cdas_pkg::OP_LOAD, 16'd0, 5'd31, 4'd11, 16'h7FFF);
    send_word(cdas_pkg::OP_ADD, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_SUB, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    // Saturation after a month crossing but no year crossing.
    send_word(cdas_pkg::OP_LOAD, 16'd0, 5'd20, 4'd10, 16'h7FFF);
    send_word(cdas_pkg::OP_ADD, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    // The first day of the smallest year holds against any subtract.
    send_word(cdas_pkg::OP_LOAD, 16'd0, 5'd1, 4'd0, 16'h8000);
    send_word(cdas_pkg::OP_SUB, 16'd1, 5'd0, 4'd0, 16'd0);
    send_word(cdas_pkg::OP_SUB, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    // The widest distance the calendar allows, then one to a clamped date.
    send_word(cdas_pkg::OP_DIST, 16'hFFFF, 5'd31, 4'd11, 16'h7FFF);
    send_word(cdas_pkg::OP_DIST, 16'd0, 5'd0, 4'd12, 16'd0);
    // A subtract that lands exactly on Jan 1 of year -1 crosses months only.
    send_word(cdas_pkg::OP_LOAD, 16'd0, 5'd1, 4'd2, 16'hFFFF);
    send_word(cdas_pkg::OP_SUB, 16'd59, 5'd0, 4'd0, 16'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      repeat (WORDS_PER_PHASE) send_random_word();
    end

    s_tvalid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/cdas_pkg.sv
design/cdas_seq.sv
design/cdas_dp.sv
design/calendar_date_add_subtract.sv
dv/calendar_date_add_subtract_checker.sv
dv/calendar_date_add_subtract_test.sv
